/* design/rpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared constants and controller/datapath interface types for ring_pan_mixer.
// ----------------------------------------------------------------------------
package rpm_pkg;

    localparam int MAX_SPEAKERS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int ACC_BITS = 32;   // accumulator width, saturating
    localparam int AZ_BITS  = 16;   // azimuth, Q0.16 of a full turn
    localparam int CFG_BITS = 5;    // speaker count register width
    localparam int SPK_BITS = 4;    // speaker index port width

    localparam logic [CFG_BITS-1:0] NUM_SPK_RESET = 5'd2;
    localparam logic [AZ_BITS:0]    GAIN_ONE      = 17'h10000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_MUL_LO,
        S_ADD_LO,
        S_MUL_HI,
        S_ADD_HI,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } state_t;

    typedef struct packed {
        logic load;        // capture input transaction
        logic scale;       // azimuth times speaker count
        logic mul_lo;      // product for lower speaker, read its sum
        logic wr_lo;       // write back lower speaker sum
        logic mul_hi;      // product for upper speaker, read its sum
        logic wr_hi;       // write back upper speaker sum
        logic drain_init;  // reset channel counter
        logic drain_rd;    // read current channel sum
        logic emit;        // load output register, step channel counter
        logic clear;       // invalidate all sums
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic out_free;
        logic last_ch;
    } stat_t;

endpackage

/* design/ring_pan_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_pan_mixer
// Pairwise linear amplitude panning of mono sources onto a ring of speakers,
// with per-speaker saturating mix sums drained at each frame end.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | sample, azimuth, frame_end
//  out     | out_valid / out_stall| speaker, mixed, clipped, final_res
//  cfg     | cfg_valid / cfg_ready| num_speakers
//
//  A source transaction runs capture, scale, then a read-modify-write of the
//  sum memory for each speaker of the pair (one memory port).
//  A frame end adds a read and an emit per channel, held while out_stall holds.
//  Reset leaves the speaker count at 2 and all sums reading as zero.
//  in_stall is high whenever a transaction or a drain is in progress.
// ----------------------------------------------------------------------------
module ring_pan_mixer #(
    parameter int MAX_SPEAKERS = rpm_pkg::MAX_SPEAKERS_DEF,
    parameter int SAMPLE_BITS  = rpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic [rpm_pkg::AZ_BITS-1:0]       azimuth,
    input  logic                              frame_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rpm_pkg::SPK_BITS-1:0]      speaker,
    output logic signed [SAMPLE_BITS-1:0]     mixed,
    output logic                              clipped,
    output logic                              final_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpm_pkg::CFG_BITS-1:0]      num_speakers
);

    logic [rpm_pkg::CFG_BITS-1:0] num_spk_reg;
    logic [rpm_pkg::CFG_BITS-1:0] spk_count;
    logic                         idle;
    rpm_pkg::cmd_t                cmd;
    rpm_pkg::stat_t               stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_spk_reg <= rpm_pkg::NUM_SPK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_spk_reg <= num_speakers;
        end
    end

    // zero counts as one speaker, counts above the ring size are clamped
    always_comb
    begin
        spk_count = num_spk_reg;
        if (num_spk_reg == '0)
        begin
            spk_count = rpm_pkg::CFG_BITS'(1);
        end
        else if (int'(num_spk_reg) > MAX_SPEAKERS)
        begin
            spk_count = rpm_pkg::CFG_BITS'(MAX_SPEAKERS);
        end
    end

    assign in_stall = !idle;

    rpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .idle     (idle),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpm_datapath #(
        .MAX_SPEAKERS (MAX_SPEAKERS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .spk_count (spk_count),
        .sample    (sample),
        .azimuth   (azimuth),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .speaker   (speaker),
        .mixed     (mixed),
        .clipped   (clipped),
        .final_res (final_res)
    );

endmodule

/* design/rpm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_ctrl
// Sequencer: walks one source through scale, two multiply-accumulate passes
// and, at frame end, the channel drain.
// ----------------------------------------------------------------------------
module rpm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           idle,
    input  rpm_pkg::stat_t stat,
    output rpm_pkg::cmd_t  cmd
);

    rpm_pkg::state_t state_reg;
    rpm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            rpm_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rpm_pkg::S_SCALE;
                end
            end
            rpm_pkg::S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = rpm_pkg::S_MUL_LO;
            end
            rpm_pkg::S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = rpm_pkg::S_ADD_LO;
            end
            rpm_pkg::S_ADD_LO:
            begin
                cmd.wr_lo  = 1'b1;
                state_next = rpm_pkg::S_MUL_HI;
            end
            rpm_pkg::S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = rpm_pkg::S_ADD_HI;
            end
            rpm_pkg::S_ADD_HI:
            begin
                cmd.wr_hi = 1'b1;
                if (stat.frame_end)
                begin
                    cmd.drain_init = 1'b1;
                    state_next     = rpm_pkg::S_DRAIN_RD;
                end
                else
                begin
                    state_next = rpm_pkg::S_IDLE;
                end
            end
            rpm_pkg::S_DRAIN_RD:
            begin
                cmd.drain_rd = 1'b1;
                state_next   = rpm_pkg::S_DRAIN_OUT;
            end
            rpm_pkg::S_DRAIN_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_ch)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = rpm_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = rpm_pkg::S_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = rpm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/rpm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_datapath
// Pan gain multiply, rounding, saturating accumulate into the per-speaker sum
// memory, and the saturating output register for the channel drain.
// ----------------------------------------------------------------------------
module rpm_datapath #(
    parameter int MAX_SPEAKERS = rpm_pkg::MAX_SPEAKERS_DEF,
    parameter int SAMPLE_BITS  = rpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpm_pkg::cmd_t                       cmd,
    output rpm_pkg::stat_t                      stat,
    input  logic [rpm_pkg::CFG_BITS-1:0]        spk_count,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [rpm_pkg::AZ_BITS-1:0]         azimuth,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rpm_pkg::SPK_BITS-1:0]        speaker,
    output logic signed [SAMPLE_BITS-1:0]       mixed,
    output logic                                clipped,
    output logic                                final_res
);

    localparam int AW  = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
    localparam int CB  = rpm_pkg::CFG_BITS;
    localparam int AB  = rpm_pkg::ACC_BITS;
    localparam int ZB  = rpm_pkg::AZ_BITS;
    localparam int PW  = SAMPLE_BITS + ZB + 2;           // product width
    localparam int CW  = PW - ZB;                        // contribution width
    localparam int SW  = ((AB > CW) ? AB : CW) + 1;      // sum width
    localparam int SCW = ZB + CB;                        // scaled azimuth width

    localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (AB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] ACC_MIN = SW'(-(64'sd1 <<< (AB - 1)));
    localparam logic signed [AB-1:0] SMP_MAX = AB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [AB-1:0] SMP_MIN = AB'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [PW-1:0] RND     = PW'(64'sd1 <<< (ZB - 1));

    // captured transaction
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [ZB-1:0]                 az_reg;
    logic                          fe_reg;

    // pair selection
    logic [CB-1:0]  lower_reg;
    logic [CB-1:0]  upper_reg;
    logic [ZB-1:0]  frac_reg;
    logic [SCW-1:0] scaled;
    logic [CB:0]    upper_wide;

    // multiply / accumulate
    logic signed [PW-1:0]   prod_reg;
    logic [ZB:0]            gain;
    logic signed [PW-1:0]   prod_next;
    logic signed [CW-1:0]   contrib;
    logic signed [SW-1:0]   base;
    logic signed [SW-1:0]   sum;
    logic signed [AB-1:0]   sum_sat;

    // sum memory, valid bits stand in for the all-zero clear
    logic signed [AB-1:0]   sum_mem [MAX_SPEAKERS];
    logic [MAX_SPEAKERS-1:0] vld_reg;
    logic signed [AB-1:0]   rd_data_reg;
    logic                   rd_vld_reg;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic                   wr_en;

    // drain
    logic [CB-1:0]          ch_reg;
    logic signed [AB-1:0]   drain_acc;
    logic signed [AB-1:0]   drain_sat;
    logic                   out_valid_reg;
    logic [rpm_pkg::SPK_BITS-1:0] speaker_reg;
    logic signed [SAMPLE_BITS-1:0] mixed_reg;
    logic                   clipped_reg;
    logic                   final_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            az_reg     <= azimuth;
            fe_reg     <= frame_end;
        end
    end

    assign scaled     = SCW'(az_reg) * SCW'(spk_count);
    assign upper_wide = {1'b0, scaled[SCW-1:ZB]} + (CB+1)'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            lower_reg <= scaled[SCW-1:ZB];
            frac_reg  <= scaled[ZB-1:0];
            // wrap from the last speaker back to speaker 0
            upper_reg <= (upper_wide >= {1'b0, spk_count}) ? '0 : upper_wide[CB-1:0];
        end
    end

    assign gain      = cmd.mul_lo ? (rpm_pkg::GAIN_ONE - {1'b0, frac_reg}) : {1'b0, frac_reg};
    assign prod_next = PW'(sample_reg) * $signed(PW'(gain));

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= prod_next;
        end
    end

    // round half up, then saturating add into the 32-bit sum
    assign contrib = CW'((prod_reg + RND) >>> ZB);
    assign base    = rd_vld_reg ? SW'(rd_data_reg) : '0;
    assign sum     = base + SW'(contrib);
    assign sum_sat = (sum > ACC_MAX) ? AB'(ACC_MAX) :
                     (sum < ACC_MIN) ? AB'(ACC_MIN) : AB'(sum);

    always_comb
    begin
        rd_addr = AW'(ch_reg);
        if (cmd.mul_lo)
        begin
            rd_addr = AW'(lower_reg);
        end
        else if (cmd.mul_hi)
        begin
            rd_addr = AW'(upper_reg);
        end
    end

    assign rd_en   = cmd.mul_lo || cmd.mul_hi || cmd.drain_rd;
    assign wr_en   = cmd.wr_lo || cmd.wr_hi;
    assign wr_addr = cmd.wr_lo ? AW'(lower_reg) : AW'(upper_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sum_mem[wr_addr] <= sum_sat;
        end
        if (rd_en)
        begin
            rd_data_reg <= sum_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // channel drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else if (cmd.drain_init)
        begin
            ch_reg <= '0;
        end
        else if (cmd.emit)
        begin
            ch_reg <= ch_reg + CB'(1);
        end
    end

    assign drain_acc = rd_vld_reg ? rd_data_reg : '0;
    assign drain_sat = (drain_acc > SMP_MAX) ? SMP_MAX :
                       (drain_acc < SMP_MIN) ? SMP_MIN : drain_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            speaker_reg <= rpm_pkg::SPK_BITS'(ch_reg);
            mixed_reg   <= SAMPLE_BITS'(drain_sat);
            clipped_reg <= (drain_sat != drain_acc);
            final_reg   <= stat.last_ch;
        end
    end

    assign stat.frame_end = fe_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.last_ch   = ((ch_reg + CB'(1)) == spk_count);

    assign out_valid = out_valid_reg;
    assign speaker   = speaker_reg;
    assign mixed     = mixed_reg;
    assign clipped   = clipped_reg;
    assign final_res = final_reg;

endmodule
